FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out for synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// ante holds in a cycle, cons holds in the same cycle
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// ante holds in a cycle, cons holds later, after the delay passed as n
`define ASSERT_DELAYED(label, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, ante, cons)
`define ASSERT_DELAYED(label, ante, n, cons)
`endif
`endif

FILE: rtl/cts_pkg.sv
// ---------------------------------------------------------------------------
// cts_pkg
// shared constants, types and the arctangent function for the angle pipeline
// ---------------------------------------------------------------------------
package cts_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Z = 2'd2;

    // internal angle scale: degrees at 2^-32
    localparam int ANG_WORK = 32;
    localparam int ZW       = ANG_WORK + 10;

    localparam logic [ZW-1:0] F90  = ZW'(90)  << ANG_WORK;
    localparam logic [ZW-1:0] F180 = ZW'(180) << ANG_WORK;
    localparam logic [ZW-1:0] F270 = ZW'(270) << ANG_WORK;
    localparam logic [ZW-1:0] F360 = ZW'(360) << ANG_WORK;

    // degrees per radian
    localparam real DEG_PER_RAD = 57.29577951308232;

    // signs of the anchor-relative offsets
    typedef struct packed {
        logic dx_zero;
        logic dx_pos;
        logic dy_zero;
        logic dy_pos;
        logic dy_neg;
        logic dz_zero;
        logic dz_pos;
    } cts_sign_t;

    // atan(2^-i) in degrees at 2^-32, elaboration only
    function automatic longint atan_deg(input int i);
        real d;
        d = $atan(2.0 ** (-i)) * DEG_PER_RAD * 4294967296.0;
        return longint'(d);
    endfunction

endpackage

FILE: rtl/cts_sqrt.sv
// ---------------------------------------------------------------------------
// cts_sqrt
// pipelined floor square root, one result bit per stage, with remainder
// ---------------------------------------------------------------------------
module cts_sqrt #(
    parameter int W = 62
) (
    input  logic              clk,
    input  logic [W-1:0]      v_in,
    output logic [(W>>1)-1:0] root,
    output logic [(W>>1):0]   rem
);

    localparam int N = W / 2;

    logic [W-1:0] v_reg [N];
    logic [W-1:0] r_reg [N];

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * k);
        logic [W-1:0] v_prev;
        logic [W-1:0] r_prev;
        logic [W-1:0] t;
        logic [W-1:0] v_next;
        logic [W-1:0] r_next;

        if (k == 0) begin : g_first
            assign v_prev = v_in;
            assign r_prev = '0;
        end
        else begin : g_rest
            assign v_prev = v_reg[k-1];
            assign r_prev = r_reg[k-1];
        end

        always_comb
        begin
            t = r_prev + ONE;
            if (v_prev >= t)
            begin
                v_next = v_prev - t;
                r_next = (r_prev >> 1) + ONE;
            end
            else
            begin
                v_next = v_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            v_reg[k] <= v_next;
            r_reg[k] <= r_next;
        end
    end

    assign root = r_reg[N-1][N-1:0];
    assign rem  = v_reg[N-1][N:0];

endmodule

FILE: rtl/cts_cordic.sv
// ---------------------------------------------------------------------------
// cts_cordic
// pipelined vectoring cordic, atan(y/x) for x, y >= 0 in degrees at 2^-32
// ---------------------------------------------------------------------------
module cts_cordic #(
    parameter int NITER = 26,
    parameter int NW    = 31
) (
    input  logic                        clk,
    input  logic [NW-1:0]               x_in,
    input  logic [NW-1:0]               y_in,
    output logic signed [cts_pkg::ZW-1:0] z_out
);

    import cts_pkg::*;

    // x grows by the cordic gain, leave headroom
    localparam int XW = NW + 4;

    logic signed [XW-1:0] x_reg [NITER];
    logic signed [XW-1:0] y_reg [NITER];
    logic signed [ZW-1:0] z_reg [NITER];

    for (genvar i = 0; i < NITER; i++) begin : g_stage
        localparam logic signed [ZW-1:0] ATAN = ZW'(atan_deg(i));
        logic signed [XW-1:0] x_prev;
        logic signed [XW-1:0] y_prev;
        logic signed [ZW-1:0] z_prev;
        logic signed [XW-1:0] sx;
        logic signed [XW-1:0] sy;
        logic signed [XW-1:0] x_next;
        logic signed [XW-1:0] y_next;
        logic signed [ZW-1:0] z_next;

        if (i == 0) begin : g_first
            assign x_prev = $signed(XW'(x_in));
            assign y_prev = $signed(XW'(y_in));
            assign z_prev = '0;
        end
        else begin : g_rest
            assign x_prev = x_reg[i-1];
            assign y_prev = y_reg[i-1];
            assign z_prev = z_reg[i-1];
        end

        always_comb
        begin
            sx = y_prev >>> i;
            sy = x_prev >>> i;
            if (!y_prev[XW-1])
            begin
                x_next = x_prev + sx;
                y_next = y_prev - sy;
                z_next = z_prev + ATAN;
            end
            else
            begin
                x_next = x_prev - sx;
                y_next = y_prev + sy;
                z_next = z_prev - ATAN;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i] <= x_next;
            y_reg[i] <= y_next;
            z_reg[i] <= z_next;
        end
    end

    assign z_out = z_reg[NITER-1];

endmodule

FILE: rtl/cartesian_to_spherical_angles.sv
// ---------------------------------------------------------------------------
// cartesian_to_spherical_angles
// distance, zenith and clockwise azimuth of a point about a programmed anchor
// ---------------------------------------------------------------------------
// A point is taken whenever start is high (busy is always low), one per clock.
// Each point gives one result. S = max(31, COORD_WIDTH + 1) is the depth of
// the bit-per-stage square root, which feeds the zenith cordic, so the two
// chains are in series. done is high for exactly one cycle with the result
// on zenith, azimuth, distance and coincident; the receiver must take it
// then, nothing is held. Write the anchor only while no item is in flight.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cartesian_to_spherical_angles #(
    parameter int COORD_WIDTH     = 24,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [cts_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [COORD_WIDTH-1:0]              cfg_data,
    // item in
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       point_x,
    input  logic signed [COORD_WIDTH-1:0]       point_y,
    input  logic signed [COORD_WIDTH-1:0]       point_z,
    // item out
    output logic                                done,
    output logic [ANGLE_FRAC_BITS+7:0]          zenith,
    output logic [ANGLE_FRAC_BITS+8:0]          azimuth,
    output logic [COORD_WIDTH:0]                distance,
    output logic                                coincident
);

    import cts_pkg::*;

    // widths along the datapath
    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;          // anchor-relative offset
    localparam int SQW    = 2 * CW;          // one square
    localparam int RW     = 2 * CW + 1;      // dx^2 + dy^2
    localparam int SW     = 2 * CW + 2;      // dx^2 + dy^2 + dz^2
    localparam int HW     = SW / 2;
    localparam int LW     = $clog2(SW + 1);
    localparam int EMW    = 5;               // normalize shift magnitude
    localparam int NW     = 31;              // cordic operand width
    localparam int SQRT_W = (SW > 62) ? SW : 62;
    localparam int LS     = SQRT_W / 2;
    localparam int NITER  = ANGLE_FRAC_BITS + 10;
    localparam int LAT    = 8 + LS + NITER;
    localparam int FD     = LAT - 3;
    localparam int ZEN_W  = ANGLE_FRAC_BITS + 8;
    localparam int AZI_W  = ANGLE_FRAC_BITS + 9;
    localparam int DIST_W = CW + 1;
    localparam int SH     = ANG_WORK - ANGLE_FRAC_BITS;

    localparam logic [ZW-1:0] HALF     = ZW'(1) << (SH - 1);
    localparam logic [ZW-1:0] AZI_FULL = ZW'(360) << ANGLE_FRAC_BITS;
    localparam logic [ZW-1:0] ZEN_MAX  = ZW'(180) << ANGLE_FRAC_BITS;

    // bit length of one half of a sum
    function automatic logic [LW-1:0] half_len(input logic [HW-1:0] v);
        logic [LW-1:0] n;
        n = '0;
        for (int i = 0; i < HW; i++)
        begin
            if (v[i])
            begin
                n = LW'(i + 1);
            end
        end
        return n;
    endfunction

    // {negative, magnitude} of the exponent that brings a sum below 2^62
    function automatic logic [EMW:0] norm_exp(input logic [LW-1:0] len);
        int l;
        l = int'(len);
        if (l <= 62)
        begin
            return {1'b0, EMW'((62 - l) >> 1)};
        end
        return {1'b1, EMW'((l - 61) >> 1)};
    endfunction

    // linear scaling by 2^e, result fits the cordic operand
    function automatic logic [NW-1:0] scale_lin(input logic [CW-1:0] m,
                                                input logic [EMW:0] e);
        logic [63:0] ext;
        ext = 64'(m);
        if (e[EMW])
        begin
            ext = ext >> e[EMW-1:0];
        end
        else
        begin
            ext = ext << e[EMW-1:0];
        end
        return ext[NW-1:0];
    endfunction

    // anchor registers
    logic signed [CW-1:0] anchor_x_reg;
    logic signed [CW-1:0] anchor_y_reg;
    logic signed [CW-1:0] anchor_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
            anchor_z_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_ANCHOR_X: anchor_x_reg <= cfg_data;
                REG_ANCHOR_Y: anchor_y_reg <= cfg_data;
                REG_ANCHOR_Z: anchor_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // the pipeline never stalls
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    logic [LAT-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LAT-2:0], accept};
        end
    end

    // stage 1: offsets from the anchor
    logic signed [DW-1:0] dx_s1_reg, dy_s1_reg, dz_s1_reg;

    always_ff @(posedge clk)
    begin
        dx_s1_reg <= DW'(point_x) - DW'(anchor_x_reg);
        dy_s1_reg <= DW'(point_y) - DW'(anchor_y_reg);
        dz_s1_reg <= DW'(point_z) - DW'(anchor_z_reg);
    end

    // stage 2: magnitudes and signs
    logic [DW-1:0]  ndx, ndy, ndz;
    logic [CW-1:0]  ax_s2_reg, ay_s2_reg, az_s2_reg;
    cts_sign_t      sign_next;
    cts_sign_t      sign_s2_reg;

    always_comb
    begin
        ndx = -dx_s1_reg;
        ndy = -dy_s1_reg;
        ndz = -dz_s1_reg;
        sign_next.dx_zero = (dx_s1_reg == '0);
        sign_next.dx_pos  = !dx_s1_reg[DW-1] && (dx_s1_reg != '0);
        sign_next.dy_zero = (dy_s1_reg == '0);
        sign_next.dy_pos  = !dy_s1_reg[DW-1] && (dy_s1_reg != '0);
        sign_next.dy_neg  = dy_s1_reg[DW-1];
        sign_next.dz_zero = (dz_s1_reg == '0);
        sign_next.dz_pos  = !dz_s1_reg[DW-1] && (dz_s1_reg != '0);
    end

    always_ff @(posedge clk)
    begin
        ax_s2_reg   <= dx_s1_reg[DW-1] ? ndx[CW-1:0] : dx_s1_reg[CW-1:0];
        ay_s2_reg   <= dy_s1_reg[DW-1] ? ndy[CW-1:0] : dy_s1_reg[CW-1:0];
        az_s2_reg   <= dz_s1_reg[DW-1] ? ndz[CW-1:0] : dz_s1_reg[CW-1:0];
        sign_s2_reg <= sign_next;
    end

    // stage 3: squares
    logic [SQW-1:0] sqx_s3_reg, sqy_s3_reg, sqz_s3_reg;
    logic [CW-1:0]  ax_s3_reg, ay_s3_reg, az_s3_reg;

    always_ff @(posedge clk)
    begin
        sqx_s3_reg <= SQW'(ax_s2_reg) * SQW'(ax_s2_reg);
        sqy_s3_reg <= SQW'(ay_s2_reg) * SQW'(ay_s2_reg);
        sqz_s3_reg <= SQW'(az_s2_reg) * SQW'(az_s2_reg);
        ax_s3_reg  <= ax_s2_reg;
        ay_s3_reg  <= ay_s2_reg;
        az_s3_reg  <= az_s2_reg;
    end

    // stage 4: planar and full sums of squares
    logic [RW-1:0] rho2_next;
    logic [RW-1:0] rho2_s4_reg;
    logic [SW-1:0] sum3_s4_reg;
    logic [CW-1:0] ax_s4_reg, ay_s4_reg, az_s4_reg;

    assign rho2_next = RW'(sqx_s3_reg) + RW'(sqy_s3_reg);

    always_ff @(posedge clk)
    begin
        rho2_s4_reg <= rho2_next;
        sum3_s4_reg <= SW'(rho2_next) + SW'(sqz_s3_reg);
        ax_s4_reg   <= ax_s3_reg;
        ay_s4_reg   <= ay_s3_reg;
        az_s4_reg   <= az_s3_reg;
    end

    // stage 5: bit length of each half of both sums
    logic [SW-1:0] rho2_ext;
    logic [LW-1:0] s_hi_s5_reg, s_lo_s5_reg, r_hi_s5_reg, r_lo_s5_reg;
    logic [RW-1:0] rho2_s5_reg;
    logic [SW-1:0] sum3_s5_reg;
    logic [CW-1:0] ax_s5_reg, ay_s5_reg, az_s5_reg;

    assign rho2_ext = SW'(rho2_s4_reg);

    always_ff @(posedge clk)
    begin
        s_hi_s5_reg <= half_len(sum3_s4_reg[SW-1:HW]);
        s_lo_s5_reg <= half_len(sum3_s4_reg[HW-1:0]);
        r_hi_s5_reg <= half_len(rho2_ext[SW-1:HW]);
        r_lo_s5_reg <= half_len(rho2_ext[HW-1:0]);
        rho2_s5_reg <= rho2_s4_reg;
        sum3_s5_reg <= sum3_s4_reg;
        ax_s5_reg   <= ax_s4_reg;
        ay_s5_reg   <= ay_s4_reg;
        az_s5_reg   <= az_s4_reg;
    end

    // stage 6: normalize exponents
    logic [LW-1:0] s_len, r_len;
    logic [EMW:0]  es_s6_reg, er_s6_reg;
    logic [RW-1:0] rho2_s6_reg;
    logic [SW-1:0] sum3_s6_reg;
    logic [CW-1:0] ax_s6_reg, ay_s6_reg, az_s6_reg;

    assign s_len = (s_hi_s5_reg != '0) ? LW'(HW) + s_hi_s5_reg : s_lo_s5_reg;
    assign r_len = (r_hi_s5_reg != '0) ? LW'(HW) + r_hi_s5_reg : r_lo_s5_reg;

    always_ff @(posedge clk)
    begin
        es_s6_reg   <= norm_exp(s_len);
        er_s6_reg   <= norm_exp(r_len);
        rho2_s6_reg <= rho2_s5_reg;
        sum3_s6_reg <= sum3_s5_reg;
        ax_s6_reg   <= ax_s5_reg;
        ay_s6_reg   <= ay_s5_reg;
        az_s6_reg   <= az_s5_reg;
    end

    // stage 7: scaled operands; zenith uses the full-sum exponent on both
    logic [RW+63:0]      rho2_wide;
    logic [61:0]         rho2_n_next;
    logic [NW-1:0]       az_n_s7_reg, ax_n_s7_reg, ay_n_s7_reg;
    logic [61:0]         rho2_n_s7_reg;
    logic [SW-1:0]       sum3_s7_reg;

    always_comb
    begin
        rho2_wide = (RW + 64)'(rho2_s6_reg);
        if (es_s6_reg[EMW])
        begin
            rho2_wide = rho2_wide >> {es_s6_reg[EMW-1:0], 1'b0};
        end
        else
        begin
            rho2_wide = rho2_wide << {es_s6_reg[EMW-1:0], 1'b0};
        end
        rho2_n_next = rho2_wide[61:0];
    end

    always_ff @(posedge clk)
    begin
        az_n_s7_reg   <= scale_lin(az_s6_reg, es_s6_reg);
        ax_n_s7_reg   <= scale_lin(ax_s6_reg, er_s6_reg);
        ay_n_s7_reg   <= scale_lin(ay_s6_reg, er_s6_reg);
        rho2_n_s7_reg <= rho2_n_next;
        sum3_s7_reg   <= sum3_s6_reg;
    end

    // square roots: distance and the planar leg of the zenith triangle
    logic [LS-1:0] root_d, root_r;
    logic [LS:0]   rem_d, rem_r;

    cts_sqrt #(
        .W (SQRT_W)
    ) u_sqrt_dist (
        .clk  (clk),
        .v_in (SQRT_W'(sum3_s7_reg)),
        .root (root_d),
        .rem  (rem_d)
    );

    cts_sqrt #(
        .W (SQRT_W)
    ) u_sqrt_rho (
        .clk  (clk),
        .v_in (SQRT_W'(rho2_n_s7_reg)),
        .root (root_r),
        .rem  (rem_r)
    );

    // cordic operands wait out the square root
    logic [3*NW-1:0] cin_line_reg [LS];

    always_ff @(posedge clk)
    begin
        cin_line_reg[0] <= {az_n_s7_reg, ay_n_s7_reg, ax_n_s7_reg};
        for (int i = 1; i < LS; i++)
        begin
            cin_line_reg[i] <= cin_line_reg[i-1];
        end
    end

    // distance rounds up when the remainder passes the root
    logic [DIST_W-1:0] dist_next;
    logic [DIST_W-1:0] dist_line_reg [NITER];
    logic              rem_unused;

    assign dist_next  = DIST_W'(root_d) + DIST_W'(rem_d > (LS + 1)'(root_d));
    assign rem_unused = ^rem_r;

    always_ff @(posedge clk)
    begin
        dist_line_reg[0] <= dist_next;
        for (int i = 1; i < NITER; i++)
        begin
            dist_line_reg[i] <= dist_line_reg[i-1];
        end
    end

    // sign flags ride along to the output stage
    cts_sign_t sign_line_reg [FD];

    always_ff @(posedge clk)
    begin
        sign_line_reg[0] <= sign_s2_reg;
        for (int i = 1; i < FD; i++)
        begin
            sign_line_reg[i] <= sign_line_reg[i-1];
        end
    end

    // zenith: atan(rho / |dz|), azimuth: atan(|dx| / |dy|)
    logic signed [ZW-1:0] zen_z, azi_z;
    logic [NW-1:0]        c_az, c_ay, c_ax;

    assign {c_az, c_ay, c_ax} = cin_line_reg[LS-1];

    cts_cordic #(
        .NITER (NITER),
        .NW    (NW)
    ) u_cordic_zen (
        .clk   (clk),
        .x_in  (c_az),
        .y_in  (root_r[NW-1:0] | {{(NW-1){1'b0}}, rem_unused & 1'b0}),
        .z_out (zen_z)
    );

    cts_cordic #(
        .NITER (NITER),
        .NW    (NW)
    ) u_cordic_azi (
        .clk   (clk),
        .x_in  (c_ay),
        .y_in  (c_ax),
        .z_out (azi_z)
    );

    // output stage: axis cases, quadrant fold, rounding, wrap at 360
    cts_sign_t          sg;
    logic               coin, rho0;
    logic [ZW-1:0]      zen_base, azi_base, zen_v, azi_v, zen_r, azi_r;
    logic [ZEN_W-1:0]   zenith_next;
    logic [AZI_W-1:0]   azimuth_next;

    logic [ZEN_W-1:0]   zenith_reg;
    logic [AZI_W-1:0]   azimuth_reg;
    logic [DIST_W-1:0]  distance_reg;
    logic               coincident_reg;

    always_comb
    begin
        sg   = sign_line_reg[FD-1];
        rho0 = sg.dx_zero && sg.dy_zero;
        coin = rho0 && sg.dz_zero;

        // clamp cordic angles to [0, 90]
        if (zen_z[ZW-1])
        begin
            zen_base = '0;
        end
        else if (zen_z > $signed(F90))
        begin
            zen_base = F90;
        end
        else
        begin
            zen_base = zen_z;
        end
        if (azi_z[ZW-1])
        begin
            azi_base = '0;
        end
        else if (azi_z > $signed(F90))
        begin
            azi_base = F90;
        end
        else
        begin
            azi_base = azi_z;
        end

        if (coin)
        begin
            zen_v = '0;
        end
        else if (rho0)
        begin
            zen_v = sg.dz_pos ? '0 : F180;
        end
        else if (sg.dz_zero)
        begin
            zen_v = F90;
        end
        else
        begin
            zen_v = sg.dz_pos ? zen_base : F180 - zen_base;
        end

        if (sg.dx_zero)
        begin
            azi_v = sg.dy_neg ? F180 : '0;
        end
        else if (sg.dy_zero)
        begin
            azi_v = sg.dx_pos ? F90 : F270;
        end
        else if (sg.dx_pos)
        begin
            azi_v = sg.dy_pos ? azi_base : F180 - azi_base;
        end
        else
        begin
            // third and fourth quadrants fold from this point's own components
            azi_v = sg.dy_neg ? F180 + azi_base : F360 - azi_base;
        end

        zen_r = (zen_v + HALF) >> SH;
        azi_r = (azi_v + HALF) >> SH;
        if (azi_r >= AZI_FULL)
        begin
            azi_r = azi_r - AZI_FULL;
        end
        zenith_next  = zen_r[ZEN_W-1:0];
        azimuth_next = azi_r[AZI_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        zenith_reg     <= zenith_next;
        azimuth_reg    <= azimuth_next;
        distance_reg   <= dist_line_reg[NITER-1];
        coincident_reg <= coin;
    end

    assign done       = valid_reg[LAT-1];
    assign zenith     = zenith_reg;
    assign azimuth    = azimuth_reg;
    assign distance   = distance_reg;
    assign coincident = coincident_reg;

    // every accepted item comes out after the fixed latency
    `ASSERT_DELAYED(a_latency, start && !busy, LAT, done)
    // a point on the anchor reports all zeros
    `ASSERT_IMPLY(a_coin_zero, done && coincident, zenith == '0 && distance == '0 && azimuth == '0)
    // angles stay in their ranges
    `ASSERT_IMPLY(a_azi_range, done, ZW'(azimuth) < AZI_FULL)
    `ASSERT_IMPLY(a_zen_range, done, ZW'(zenith) <= ZEN_MAX)

endmodule
